FILE: sv/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg - shared types and constants for the packed slot field unit
// Field layout of a section, operation codes and stage transfer records.
// ----------------------------------------------------------------------------
package psf_pkg;

    localparam int SLOT_COUNT = 10;
    localparam int SECTION_W  = 16;
    localparam int SECTIONS   = 4;
    localparam int ID_W       = 6;
    localparam int WORD_W     = SECTION_W * SECTIONS;
    localparam int ID_LIMIT   = 63;
    localparam int SLOT_LIMIT = 1023;

    // amount / 10 == (amount * RECIP_MUL) >> RECIP_SHIFT for every 16-bit amount
    localparam logic [16:0] RECIP_MUL   = 17'd52429;
    localparam int          RECIP_SHIFT = 19;
    localparam int          QUOT_W      = 13;

    typedef enum logic [3:0] {
        MODE_READ        = 4'd0,
        MODE_SET_SECTION = 4'd1,
        MODE_SET_ID      = 4'd2,
        MODE_SET_SLOTS   = 4'd3,
        MODE_TOGGLE      = 4'd4,
        MODE_ADD         = 4'd5,
        MODE_REMOVE      = 4'd6,
        MODE_ROTL        = 4'd7,
        MODE_ROTR        = 4'd8
    } mode_t;

    typedef struct packed {
        logic [3:0]            mode;
        logic [WORD_W-1:0]     word;
        logic [1:0]            sec;
        logic [SECTION_W-1:0]  nv;
        logic [3:0]            slot;
        logic [15:0]           amt;
        logic [SECTION_W-1:0]  secw;
        logic [3:0]            cnt;
        logic [QUOT_W-1:0]     quot;
    } stage_a_t;

    typedef struct packed {
        logic [WORD_W-1:0]     word;
        logic [1:0]            sec;
        logic [SECTION_W-1:0]  secw;
        logic [3:0]            cnt;
        logic                  write;
        logic [SECTION_W-1:0]  new_sec;
        logic                  rejected;
    } stage_b_t;

    function automatic logic [3:0] popcount10(input logic [SLOT_COUNT-1:0] s);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            c = c + {3'b000, s[i]};
        end
        return c;
    endfunction

endpackage

FILE: sv/psf_decode.sv
// ----------------------------------------------------------------------------
// psf_decode - first pipeline stage
// Pick the addressed section, count its filled slots, divide amount by ten.
// ----------------------------------------------------------------------------
module psf_decode
    import psf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [3:0]           mode,
    input  logic [WORD_W-1:0]    word_in,
    input  logic [1:0]           section_sel,
    input  logic [SECTION_W-1:0] new_value,
    input  logic [3:0]           slot_sel,
    input  logic [15:0]          amount,
    output logic                 a_valid,
    output stage_a_t             a_data
);

    logic                 valid_reg;
    stage_a_t             data_reg;
    stage_a_t             data_next;
    logic [SECTION_W-1:0] secw;
    logic [32:0]          product;

    always_comb
    begin
        secw    = word_in[section_sel*SECTION_W +: SECTION_W];
        product = {17'b0, amount} * {16'b0, RECIP_MUL};

        data_next.mode = mode;
        data_next.word = word_in;
        data_next.sec  = section_sel;
        data_next.nv   = new_value;
        data_next.slot = slot_sel;
        data_next.amt  = amount;
        data_next.secw = secw;
        data_next.cnt  = popcount10(secw[SLOT_COUNT-1:0]);
        data_next.quot = product[RECIP_SHIFT +: QUOT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            data_reg <= data_next;
    end

    assign a_valid = valid_reg;
    assign a_data  = data_reg;

endmodule

FILE: sv/psf_slot_op.sv
// ----------------------------------------------------------------------------
// psf_slot_op - second pipeline stage
// Apply the operation to the addressed section and form its new value.
// ----------------------------------------------------------------------------
module psf_slot_op
    import psf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     a_valid,
    input  stage_a_t a_data,
    output logic     b_valid,
    output stage_b_t b_data
);

    logic                  valid_reg;
    stage_b_t              data_reg;
    stage_b_t              data_next;
    logic [SLOT_COUNT-1:0] slots;
    logic [ID_W-1:0]       idb;
    logic [15:0]           quot_x10;
    logic [3:0]            rem;
    logic [2*SLOT_COUNT-1:0] dbl;
    logic [2*SLOT_COUNT-1:0] shl;
    logic [2*SLOT_COUNT-1:0] shr;
    logic                  add_full;
    logic                  rem_all;

    // flip the n lowest slots whose state differs from want_set
    function automatic logic [SLOT_COUNT-1:0] fill_low(
        input logic [SLOT_COUNT-1:0] s,
        input logic [3:0]            n,
        input logic                  want_set
    );
        logic [SLOT_COUNT-1:0] targets;
        logic [SLOT_COUNT-1:0] mask;
        logic [SLOT_COUNT-1:0] r;
        targets = want_set ? ~s : s;
        r       = s;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            mask = (SLOT_COUNT'(1) << i) - SLOT_COUNT'(1);
            if (targets[i] && (popcount10(targets & mask) < n))
                r[i] = ~s[i];
        end
        return r;
    endfunction

    always_comb
    begin
        slots    = a_data.secw[SLOT_COUNT-1:0];
        idb      = a_data.secw[SECTION_W-1:SLOT_COUNT];
        quot_x10 = {a_data.quot, 3'b000} + {2'b00, a_data.quot, 1'b0};
        rem      = a_data.amt[3:0] - quot_x10[3:0];
        dbl      = {slots, slots};
        shl      = dbl << rem;
        shr      = dbl >> rem;
        add_full = ({1'b0, a_data.amt} + {13'b0, a_data.cnt}) >= 17'(SLOT_COUNT);
        rem_all  = a_data.amt >= {12'b0, a_data.cnt};

        data_next.word     = a_data.word;
        data_next.sec      = a_data.sec;
        data_next.secw     = a_data.secw;
        data_next.cnt      = a_data.cnt;
        data_next.write    = 1'b0;
        data_next.new_sec  = a_data.secw;
        data_next.rejected = 1'b0;

        case (a_data.mode)
            MODE_SET_SECTION:
            begin
                data_next.write   = 1'b1;
                data_next.new_sec = a_data.nv;
            end
            MODE_SET_ID:
            begin
                if (a_data.nv > 16'(ID_LIMIT))
                    data_next.rejected = 1'b1;
                else
                begin
                    data_next.write   = 1'b1;
                    data_next.new_sec = {a_data.nv[ID_W-1:0], slots};
                end
            end
            MODE_SET_SLOTS:
            begin
                if (a_data.nv > 16'(SLOT_LIMIT))
                    data_next.rejected = 1'b1;
                else
                begin
                    data_next.write   = 1'b1;
                    data_next.new_sec = {idb, a_data.nv[SLOT_COUNT-1:0]};
                end
            end
            MODE_TOGGLE:
            begin
                if (a_data.slot < 4'(SLOT_COUNT))
                begin
                    data_next.write   = 1'b1;
                    data_next.new_sec = {idb, slots ^ (SLOT_COUNT'(1) << a_data.slot)};
                end
            end
            MODE_ADD:
            begin
                data_next.write = 1'b1;
                if (add_full)
                    data_next.new_sec = {idb, {SLOT_COUNT{1'b1}}};
                else
                    data_next.new_sec = {idb, fill_low(slots, a_data.amt[3:0], 1'b1)};
            end
            MODE_REMOVE:
            begin
                data_next.write = 1'b1;
                if (rem_all)
                    data_next.new_sec = {idb, {SLOT_COUNT{1'b0}}};
                else
                    data_next.new_sec = {idb, fill_low(slots, a_data.amt[3:0], 1'b0)};
            end
            MODE_ROTL:
            begin
                data_next.write   = 1'b1;
                data_next.new_sec = {idb, shl[2*SLOT_COUNT-1:SLOT_COUNT]};
            end
            MODE_ROTR:
            begin
                data_next.write   = 1'b1;
                data_next.new_sec = {idb, shr[SLOT_COUNT-1:0]};
            end
            default:
            begin
                data_next.write = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= a_valid;
    end

    always_ff @(posedge clk)
    begin
        if (a_valid)
            data_reg <= data_next;
    end

    assign b_valid = valid_reg;
    assign b_data  = data_reg;

endmodule

FILE: sv/psf_merge.sv
// ----------------------------------------------------------------------------
// psf_merge - third pipeline stage
// Insert the new section into the word and register the result ports.
// ----------------------------------------------------------------------------
module psf_merge
    import psf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 b_valid,
    input  stage_b_t             b_data,
    output logic                 done,
    output logic [WORD_W-1:0]    word_out,
    output logic [SECTION_W-1:0] section_word,
    output logic [ID_W-1:0]      section_id,
    output logic [SLOT_COUNT-1:0] slot_bits,
    output logic [3:0]           item_count,
    output logic                 rejected
);

    logic                 done_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [WORD_W-1:0]    word_next;
    logic [SECTION_W-1:0] secw_reg;
    logic [3:0]           cnt_reg;
    logic                 rejected_reg;

    always_comb
    begin
        word_next = b_data.word;
        for (int s = 0; s < SECTIONS; s++)
        begin
            if (b_data.write && (b_data.sec == 2'(s)))
                word_next[s*SECTION_W +: SECTION_W] = b_data.new_sec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= b_valid;
    end

    always_ff @(posedge clk)
    begin
        if (b_valid)
        begin
            word_reg     <= word_next;
            secw_reg     <= b_data.secw;
            cnt_reg      <= b_data.cnt;
            rejected_reg <= b_data.rejected;
        end
    end

    assign done         = done_reg;
    assign word_out     = word_reg;
    assign section_word = secw_reg;
    assign section_id   = secw_reg[SECTION_W-1:SLOT_COUNT];
    assign slot_bits    = secw_reg[SLOT_COUNT-1:0];
    assign item_count   = cnt_reg;
    assign rejected     = rejected_reg;

endmodule

FILE: sv/packed_slot_field_unit.sv
// ----------------------------------------------------------------------------
// packed_slot_field_unit - section update unit for a word of four slot fields
// Each 16-bit section holds a 6-bit id above 10 slot bits; one operation is
// applied to the addressed section and the whole word is returned.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   -----------------------------------------------
//  command   start / busy       mode, word_in, section_sel, new_value,
//                               slot_sel, amount
//  result    done (one cycle)   word_out, section_word, section_id, slot_bits,
//                               item_count, rejected
//
// A command transfers on a clock edge with start high and busy low. busy is
// always low: one command enters every cycle. The result appears after its
// command passes the three register stages (decode, slot operation, merge),
// with done high for one cycle, in command order. The receiver cannot stall,
// so nothing holds. Reset clears the stage valid bits only; data registers
// keep whatever they hold and are ignored until done.
// ----------------------------------------------------------------------------
module packed_slot_field_unit
    import psf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [3:0]            mode,
    input  logic [WORD_W-1:0]     word_in,
    input  logic [1:0]            section_sel,
    input  logic [SECTION_W-1:0]  new_value,
    input  logic [3:0]            slot_sel,
    input  logic [15:0]           amount,
    output logic                  done,
    output logic [WORD_W-1:0]     word_out,
    output logic [SECTION_W-1:0]  section_word,
    output logic [ID_W-1:0]       section_id,
    output logic [SLOT_COUNT-1:0] slot_bits,
    output logic [3:0]            item_count,
    output logic                  rejected
);

    logic     a_valid;
    stage_a_t a_data;
    logic     b_valid;
    stage_b_t b_data;

    // the pipeline never backs up, so always take the next command
    assign busy = 1'b0;

    // stage 1: select section, count slots, divide amount by ten
    psf_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start & ~busy),
        .mode        (mode),
        .word_in     (word_in),
        .section_sel (section_sel),
        .new_value   (new_value),
        .slot_sel    (slot_sel),
        .amount      (amount),
        .a_valid     (a_valid),
        .a_data      (a_data)
    );

    // stage 2: run the operation on the section, flag rejected writes
    psf_slot_op u_slot_op (
        .clk     (clk),
        .rst_n   (rst_n),
        .a_valid (a_valid),
        .a_data  (a_data),
        .b_valid (b_valid),
        .b_data  (b_data)
    );

    // stage 3: drop the new section into the word, drive the result ports
    psf_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .b_valid      (b_valid),
        .b_data       (b_data),
        .done         (done),
        .word_out     (word_out),
        .section_word (section_word),
        .section_id   (section_id),
        .slot_bits    (slot_bits),
        .item_count   (item_count),
        .rejected     (rejected)
    );

endmodule

FILE: sv/psf_checker.sv
// ----------------------------------------------------------------------------
// psf_checker - port-level checks for the packed slot field unit
// Latency, spurious results, field consistency and item count seen at the top-level ports.
// ----------------------------------------------------------------------------
module psf_checker
    import psf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [SECTION_W-1:0]  section_word,
    input logic [ID_W-1:0]       section_id,
    input logic [SLOT_COUNT-1:0] slot_bits,
    input logic [3:0]            item_count
);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result did not follow command after three cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without a command three cycles earlier");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (section_id == section_word[SECTION_W-1:SLOT_COUNT]) &&
                 (slot_bits == section_word[SLOT_COUNT-1:0]))
        else $error("section fields disagree with section word");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (item_count == popcount10(slot_bits)))
        else $error("item count does not match slot bits");

endmodule

bind packed_slot_field_unit psf_checker u_psf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .section_word (section_word),
    .section_id   (section_id),
    .slot_bits    (slot_bits),
    .item_count   (item_count)
);
